[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the band averager.
// Define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/obsa_pkg.sv]
// Package for the octave band spectrum averager.
// Holds the band edge ROM, register indexes and shared widths.
package obsa_pkg;
  localparam int FREQ_W = 19;
  localparam int PART_W = 24;
  localparam int MAG_W  = 25;
  localparam int SQ_W   = 50;
  localparam int EDGE_W = 20;
  localparam int EDGE_LOW_J  = -44;
  localparam int EDGE_HIGH_J = 15;
  localparam logic [EDGE_W-1:0] EDGE_ABOVE = 20'd524288;

  typedef enum logic [1:0] {
    REG_BAND_MODE  = 2'd0,
    REG_FIRST_BAND = 2'd1,
    REG_BAND_COUNT = 2'd2
  } reg_idx_t;

  typedef logic [EDGE_W-1:0] edge_t;

  localparam edge_t EDGE_ROM [60] = '{
    20'd1, 20'd1, 20'd1, 20'd1,
    20'd1, 20'd2, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd7, 20'd9, 20'd11,
    20'd14, 20'd18, 20'd23, 20'd28, 20'd36, 20'd45, 20'd57, 20'd71, 20'd90,
    20'd113, 20'd143, 20'd180, 20'd226, 20'd285, 20'd358, 20'd451, 20'd568,
    20'd715, 20'd900, 20'd1133, 20'd1426, 20'd1795, 20'd2260, 20'd2845,
    20'd3582, 20'd4509, 20'd5677, 20'd7147, 20'd8997, 20'd11327, 20'd14260,
    20'd17952, 20'd22601, 20'd28452, 20'd35820, 20'd45094, 20'd56770,
    20'd71469, 20'd89975, 20'd113271, 20'd142600, 20'd179523, 20'd226006,
    20'd284525, 20'd358195, 20'd450941
  };

  // Look up edge j, saturating below and above the table.
  function automatic edge_t edge_at(input logic signed [9:0] j);
    logic signed [9:0] off;
    off = j - 10'(EDGE_LOW_J);
    if (j < 10'(EDGE_LOW_J)) return '0;
    if (j > 10'(EDGE_HIGH_J)) return EDGE_ABOVE;
    return EDGE_ROM[off[5:0]];
  endfunction
endpackage

[hw/rtl/octave_band_spectrum_averager_top.sv]
// Octave band averager: one bin per transfer, one result per finished band.
// A bin passes through a sequential square root (2 bits a step, with
// a registered squaring stage); each emitted band then goes through
// the shared restoring divider (one quotient bit a cycle). One bin at a time.
// Reset (rst_n low, synchronous) clears the control state, output valid,
// band state and accumulator, and sets octave mode, first band -17, 31 bands.
`include "assert_macros.svh"
module octave_band_spectrum_averager_top import obsa_pkg::*; #(
  parameter int MAX_BANDS     = 48,
  parameter int MAX_BINS_LOG2 = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [18:0] bin_frequency, [42:19] real_part, [66:43] imag_part, [71:67] zero
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,       // last_bin
  output logic        out_tvalid,
  input  logic        out_tready,
  // [23:0] band_mean, [29:24] band_number, [31:30] zero
  output logic [31:0] out_tdata,
  output logic        out_tuser       // final_band
);
  localparam int SUM_W = MAG_W + MAX_BINS_LOG2;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);
  localparam logic [MAX_BINS_LOG2-1:0] CAP = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ROOT, S_MEM, S_EVAL, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic        mode_r;
  logic [5:0]  first_r, count_r;
  logic [5:0]  band_r;
  logic        done_r;
  logic [FREQ_W-1:0] freq_r;
  logic        last_r;
  logic [PART_W-1:0] ar_r, ai_r;
  logic [SQ_W-1:0]   rad_r;
  logic [MAG_W-1:0]  root_r;
  logic [4:0]        step_r;
  logic        flush_r;

  // Band accumulator memory: one entry holding sum and count, registered read.
  logic [SUM_W+MAX_BINS_LOG2-1:0] acc_mem [1];
  logic [SUM_W+MAX_BINS_LOG2-1:0] acc_rd_r;
  logic        acc_we;
  logic [SUM_W+MAX_BINS_LOG2-1:0] acc_wd;

  logic [SUM_W-1:0] num_r, quo_r;
  logic [SUM_W:0]   rem_r;
  logic [MAX_BINS_LOG2-1:0] den_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic [PART_W-1:0] mean_r;
  logic [5:0] onum_r;
  logic       ofin_r;
  logic       oval_r;

  logic [6:0] cnt_eff;
  logic signed [9:0] k, lo_j, hi_j;
  edge_t lo_e, hi_e;
  logic [SUM_W-1:0] sum_q;
  logic [MAX_BINS_LOG2-1:0] bins_q;
  logic [SUM_W:0] rem_sh;
  logic [PART_W-1:0] re_abs, im_abs;

  assign cnt_eff = ({1'b0, count_r} > 7'(MAX_BANDS)) ? 7'(MAX_BANDS) : {1'b0, count_r};
  assign k    = 10'($signed(first_r)) + 10'(band_r);
  assign lo_j = mode_r ? k : 10'(3 * k - 1);
  assign hi_j = mode_r ? 10'(k + 1) : 10'(3 * k + 2);
  assign lo_e = edge_at(lo_j);
  assign hi_e = edge_at(hi_j);
  assign sum_q  = acc_rd_r[SUM_W+MAX_BINS_LOG2-1:MAX_BINS_LOG2];
  assign bins_q = acc_rd_r[MAX_BINS_LOG2-1:0];
  assign rem_sh = {rem_r[SUM_W-1:0], num_r[SUM_W-1]};
  assign re_abs = in_tdata[42] ? PART_W'(-in_tdata[42:19]) : in_tdata[42:19];
  assign im_abs = in_tdata[66] ? PART_W'(-in_tdata[66:43]) : in_tdata[66:43];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = {2'b00, onum_r, mean_r};
  assign out_tuser  = ofin_r;

  // Hold the accumulator memory, read data registered; forward a write
  // landing in the same cycle so the next read sees it.
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[0] <= acc_wd;
    end
    acc_rd_r <= acc_we ? acc_wd : acc_mem[0];
  end

  // Square root working values, digit by digit.
  logic [SQ_W+1:0] rem2;
  logic [SQ_W+1:0] tst;
  logic [SQ_W-1:0] sqv_r;
  assign rem2 = {rad_r, sqv_r[SQ_W-1 -: 2]};
  assign tst  = {{(SQ_W - MAG_W){1'b0}}, root_r, 2'b01};

  always_ff @(posedge clk) begin
    acc_we <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= 1'b0;
      first_r <= 6'h2f;
      count_r <= 6'd31;
      band_r  <= '0;
      done_r  <= 1'b0;
      oval_r  <= 1'b0;
      acc_we  <= 1'b1;
      acc_wd  <= '0;
      step_r  <= '0;
      flush_r <= 1'b0;
    end else begin
      // Take configuration writes.
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BAND_MODE:  mode_r  <= cfg_data[0];
          REG_FIRST_BAND: first_r <= cfg_data;
          REG_BAND_COUNT: count_r <= cfg_data;
          default: ;
        endcase
      end
      if (oval_r && out_tready) oval_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          freq_r <= in_tdata[18:0];
          last_r <= in_tlast;
          ar_r   <= re_abs;
          ai_r   <= im_abs;
          state_r <= S_SQ;
        end
        S_SQ: begin
          // Registered squares, then root over 25 digit steps.
          sqv_r  <= SQ_W'(ar_r * ar_r) + SQ_W'(ai_r * ai_r);
          rad_r  <= '0;
          root_r <= '0;
          step_r <= 5'd25;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (rem2 >= tst) begin
            rad_r  <= SQ_W'(rem2 - tst);
            root_r <= {root_r[MAG_W-2:0], 1'b1};
          end else begin
            rad_r  <= SQ_W'(rem2);
            root_r <= {root_r[MAG_W-2:0], 1'b0};
          end
          sqv_r  <= {sqv_r[SQ_W-3:0], 2'b00};
          step_r <= step_r - 5'd1;
          if (step_r == 5'd1) begin
            flush_r <= 1'b0;
            state_r <= S_MEM;
          end
        end
        S_MEM: state_r <= S_EVAL;
        S_EVAL: begin
          if (!oval_r || out_tready) begin
            if (!flush_r && !done_r && {1'b0, band_r} < cnt_eff &&
                {1'b0, freq_r} >= lo_e) begin
              if ({1'b0, band_r} < cnt_eff && {1'b0, freq_r} >= hi_e) begin
                state_r <= S_DIV;
              end else if ({1'b0, band_r} < cnt_eff) begin
                if (bins_q < CAP) begin
                  acc_we <= 1'b1;
                  acc_wd <= {SUM_W'(sum_q + SUM_W'(root_r)), bins_q + 1'b1};
                end
                flush_r <= last_r;
                state_r <= last_r ? S_MEM : S_IDLE;
              end
            end else if (last_r && {1'b0, band_r} < cnt_eff) begin
              flush_r <= 1'b1;
              state_r <= S_DIV;
            end else begin
              if (last_r) begin
                band_r <= '0;
                done_r <= 1'b0;
                acc_we <= 1'b1;
                acc_wd <= '0;
              end
              state_r <= S_IDLE;
            end
            num_r  <= sum_q;
            den_r  <= bins_q;
            rem_r  <= '0;
            quo_r  <= '0;
            dcnt_r <= DIV_CNT_W'(SUM_W);
          end
        end
        S_DIV: begin
          // Restoring divide, one quotient bit a cycle.
          if (rem_sh >= (SUM_W+1)'(den_r)) begin
            rem_r <= rem_sh - (SUM_W+1)'(den_r);
            quo_r <= {quo_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[SUM_W-2:0], 1'b0};
          end
          num_r  <= {num_r[SUM_W-2:0], 1'b0};
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == DIV_CNT_W'(1)) state_r <= S_OUT;
        end
        S_OUT: if (!oval_r) begin
          mean_r <= (den_r == '0) ? '0 : quo_r[PART_W-1:0];
          onum_r <= band_r;
          ofin_r <= ({1'b0, band_r} + 7'd1 == cnt_eff);
          oval_r <= 1'b1;
          band_r <= band_r + 6'd1;
          acc_we <= 1'b1;
          acc_wd <= '0;
          if ({1'b0, band_r} + 7'd1 >= cnt_eff && !flush_r && !last_r)
            done_r <= 1'b1;
          state_r <= S_MEM;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst_n, oval_r && !out_tready, oval_r && $stable(out_tdata))
  `ASSERT_IMPL(a_no_in_busy, clk, rst_n, (state_r != S_IDLE) |-> !in_tready)
  `ASSERT_IMPL(a_band_range, clk, rst_n, oval_r |-> ({1'b0, onum_r} < 7'(MAX_BANDS)))
endmodule

[bench/testbench.sv]
// Self-checking bench for the octave band spectrum averager.
// Depends on obsa_pkg and octave_band_spectrum_averager_top; predicts each band
// mean in a small scoreboard class and compares every result transfer in order.
`timescale 1ns / 100ps

class band_scoreboard;
  typedef struct {
    logic [23:0] mean;
    logic [5:0]  number;
    logic        last_band;
  } band_result_t;

  band_result_t pending_bands[$];
  int unsigned  errors;

  // Shadow of the configuration and the band state
  logic        tri_mode;
  logic [5:0]  first_k;
  logic [5:0]  num_bands;
  logic [5:0]  band_pos;
  logic [63:0] mag_total;
  logic [11:0] bin_tally;
  logic        spectrum_full;

  function new();
    tri_mode = 1'b0;
    first_k = 6'(-17);
    num_bands = 6'd31;
    clear_bands();
    errors = 0;
  endfunction

  function void clear_bands();
    band_pos = '0;
    mag_total = '0;
    bin_tally = '0;
    spectrum_full = 1'b0;
  endfunction

  function void set_reg(obsa_pkg::reg_idx_t idx, logic [5:0] val);
    case (idx)
      obsa_pkg::REG_BAND_MODE:  tri_mode = val[0];
      obsa_pkg::REG_FIRST_BAND: first_k = val;
      obsa_pkg::REG_BAND_COUNT: num_bands = val;
      default: ;
    endcase
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function int unsigned edge_hz(int j);
    if (j < obsa_pkg::EDGE_LOW_J) return 0;
    if (j > obsa_pkg::EDGE_HIGH_J) return 524288;
    return obsa_pkg::EDGE_ROM[j - obsa_pkg::EDGE_LOW_J];
  endfunction

  function int unsigned band_edge(logic [5:0] pos, bit upper);
    int k;
    k = int'($signed(first_k)) + int'(pos);
    if (tri_mode) return edge_hz(upper ? k + 1 : k);
    return edge_hz(upper ? 3 * k + 2 : 3 * k - 1);
  endfunction

  // Largest root whose square fits, one bit at a time from the top
  function logic [24:0] root_of(logic [48:0] v);
    logic [24:0] r;
    logic [24:0] t;
    r = '0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (25'd1 << b);
      if (50'(t) * 50'(t) <= 50'(v)) r = t;
    end
    return r;
  endfunction

  function void close_band(logic [5:0] cnt);
    band_result_t res;
    res.mean = (bin_tally != 0) ? 24'(mag_total / bin_tally) : 24'd0;
    res.number = band_pos;
    res.last_band = (band_pos + 6'd1 == cnt);
    pending_bands.insert(pending_bands.size(), res);
    band_pos++;
    mag_total = '0;
    bin_tally = '0;
  endfunction

  function void note_bin(logic [18:0] freq, logic signed [23:0] re,
                         logic signed [23:0] im, logic last_bin);
    logic [24:0] ar;
    logic [24:0] ai;
    logic [24:0] mag;
    logic [5:0]  cnt;
    ar = (re < 0) ? 25'(-26'(re)) : 25'(re);
    ai = (im < 0) ? 25'(-26'(im)) : 25'(im);
    mag = root_of(49'(ar) * 49'(ar) + 49'(ai) * 49'(ai));
    cnt = (num_bands > 6'd48) ? 6'd48 : num_bands;
    if (!spectrum_full && band_pos < cnt && freq >= band_edge(band_pos, 1'b0)) begin
      while (band_pos < cnt && freq >= band_edge(band_pos, 1'b1)) close_band(cnt);
      if (band_pos < cnt) begin
        // Saturate the bin tally of a band
        if (bin_tally != 12'hFFF) begin
          mag_total += 64'(mag);
          bin_tally++;
        end
      end else begin
        spectrum_full = 1'b1;
      end
    end
    if (last_bin) begin
      while (band_pos < cnt) close_band(cnt);
      clear_bands();
    end
  endfunction

  task check_band(logic [23:0] mean, logic [5:0] number, logic last_band);
    band_result_t exp_res;
    if (pending_bands.size() == 0) begin
      report($sformatf("unexpected band %0d mean %0d", number, mean));
      return;
    end
    exp_res = pending_bands.pop_front();
    if (mean !== exp_res.mean)
      report($sformatf("band %0d mean %0d, want %0d", exp_res.number, mean, exp_res.mean));
    if (number !== exp_res.number)
      report($sformatf("band number %0d, want %0d", number, exp_res.number));
    if (last_band !== exp_res.last_band)
      report($sformatf("band %0d final flag %0b, want %0b", exp_res.number,
                       last_band, exp_res.last_band));
  endtask
endclass

module testbench;
  import obsa_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  band_scoreboard bands = new();
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bins_sent = 0;

  octave_band_spectrum_averager_top dut (.*);

  always #10 clk = ~clk;

  // Random backpressure on results; check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      bands.check_band(out_tdata[23:0], out_tdata[29:24], out_tuser);
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bands.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_bin(logic [18:0] freq, logic [23:0] re, logic [23:0] im,
                          logic last_bin);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, im, re, freq};
    in_tlast <= last_bin;
    do @(posedge clk); while (!in_tready);
    bands.note_bin(freq, re, im, last_bin);
    bins_sent++;
  endtask

  // Wait for every band result, then let a bin with no result finish
  task automatic drain();
    in_tvalid <= 1'b0;
    while (bands.pending_bands.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic configure(logic mode, logic [5:0] first, logic [5:0] cnt);
    drain();
    write_reg(REG_BAND_MODE, {5'd0, mode});
    write_reg(REG_FIRST_BAND, first);
    write_reg(REG_BAND_COUNT, cnt);
  endtask

  function automatic logic [23:0] rand_part();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 15)) - 24'd8;
      1: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // One spectrum: mostly rising frequencies, some in scrambled order
  task automatic send_spectrum();
    logic [18:0] freqs[];
    int n;
    n = $urandom_range(1, 10);
    freqs = new[n];
    foreach (freqs[i])
      freqs[i] = 19'($urandom_range(0, (1 << $urandom_range(1, 19)) - 1));
    if ($urandom_range(0, 99) >= 15) freqs.sort();
    foreach (freqs[i]) send_bin(freqs[i], rand_part(), rand_part(), i == n - 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bins under the reset configuration
    send_bin(19'd0, 24'h800000, 24'h7FFFFF, 1'b0);
    send_bin(19'd16000, 24'h7FFFFF, 24'h800000, 1'b0);
    send_bin(19'd16000, 24'd0, 24'd0, 1'b0);
    send_bin(19'd100, 24'd5, 24'd5, 1'b0);          // out of order, ignored
    send_bin(19'h7FFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0); // top of range, band 22
    send_bin(19'd300000, 24'd1, 24'd1, 1'b0);        // out of order, ignored
    send_bin(19'd1000, 24'd2, 24'd2, 1'b1);
    send_bin(19'd20000, 24'd3, 24'd4, 1'b1);         // lone last bin

    // No bands at all
    configure(1'b1, 6'(-24), 6'd0);
    send_bin(19'd20000, 24'd3, 24'd4, 1'b0);
    send_bin(19'd30000, 24'd3, 24'd4, 1'b1);

    // Random spectra over several settings and idling phases
    bins_sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(1'b1, 6'(-24), 6'd48);
        1: configure(1'b0, 6'd15, 6'd1);
        2: configure(1'b0, 6'(-24), 6'd63);
        3: configure(1'b0, 6'(-17), 6'd31);
        default: configure(1'($urandom_range(0, 1)), 6'($urandom_range(0, 39) - 24),
                           6'($urandom_range(0, 63)));
      endcase
      gap_pct = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 21 : 0;
      stall_pct = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 21 : 0;
      while (bins_sent < (ph + 1) * 26) begin
        send_spectrum();
        if (ph == 5 && bins_sent < 150) drain();  // hold off until results are in
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (bands.pending_bands.size() != 0)
      bands.report($sformatf("%0d band results never came", bands.pending_bands.size()));
    if (bands.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
